@@ rtl/u2da_pkg.sv @@
// ----------------------------------------------------------------------------
// u2da_pkg
// shared types, constants and helpers for the decimal ascii converter
// ----------------------------------------------------------------------------
package u2da_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int IN_WIDTH           = 32;
   localparam int CHAR_WIDTH         = 6;
   localparam int DEC_BASE           = 10;
   localparam int DIGIT_BITS         = 4;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // decimal length of the largest value of the given width
   function automatic int dec_digits(input int bits);
      longint unsigned v;
      int              n;
      v = (bits >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << bits) - 64'd1);
      n = 1;
      while (v >= 64'(DEC_BASE)) begin
         v = v / DEC_BASE;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

@@ rtl/unsigned_to_decimal_ascii_top.sv @@
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii_top
// converts an unsigned binary word into ascii decimal digits, msd first
// ----------------------------------------------------------------------------
// usage:
//   req_ channel takes one binary word (req_value). only the low VALUE_BITS
//   bits are converted. rsp_ channel returns one word per decimal digit,
//   most significant first, leading zeros dropped, rsp_last on the final one.
//   zero gives the single digit '0'.
// timing:
//   a word is taken in idle, then the convert state builds the bcd register
//   with shift-add-3, one binary bit a cycle, then the skip state drops the
//   leading zero digits, then the emit state sends the digits one by one,
//   each waiting while the output register holds a digit not yet taken. the
//   next word is taken in idle once the final digit is in the output register.
// reset:
//   synchronous active high reset returns to idle and drops rsp_valid.
// stall:
//   a low rsp_ready holds the output register and the digit shifter; the
//   next word can still be taken while the final digit waits.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii_top #(
   parameter int VALUE_BITS = u2da_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [u2da_pkg::IN_WIDTH-1:0]   req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [u2da_pkg::CHAR_WIDTH-1:0] rsp_digit_char,
   output logic                            rsp_last
);

   localparam int NUM_DIGITS = u2da_pkg::dec_digits(VALUE_BITS);
   localparam int DB         = u2da_pkg::DIGIT_BITS;
   localparam int BCD_W      = NUM_DIGITS * DB;
   localparam int LOAD_BITS  = (VALUE_BITS < u2da_pkg::IN_WIDTH) ?
                               VALUE_BITS : u2da_pkg::IN_WIDTH;
   localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

   u2da_pkg::state_type           state_ff, state_in;
   logic [VALUE_BITS-1:0]         bin_ff, bin_in;
   logic [BCD_W-1:0]              bcd_ff, bcd_in;
   logic [BCD_W-1:0]              bcd_adj;
   logic [BIT_CNT_W-1:0]          bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]          dig_cnt_ff, dig_cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [u2da_pkg::CHAR_WIDTH-1:0] char_ff, char_in;
   logic                          last_ff, last_in;
   logic [DB-1:0]                 top_digit;
   logic                          out_free;

   assign top_digit = bcd_ff[BCD_W-1 -: DB];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // add 3 to every bcd digit of five or more
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[i*DB +: DB] = (bcd_ff[i*DB +: DB] >= 4'd5) ?
                               bcd_ff[i*DB +: DB] + 4'd3 : bcd_ff[i*DB +: DB];
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      char_in      = char_ff;
      last_in      = last_ff;
      req_ready    = 1'b0;
      case (state_ff)
         u2da_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               bin_in     = VALUE_BITS'(req_value[LOAD_BITS-1:0]);
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(VALUE_BITS - 1);
               state_in   = u2da_pkg::ST_CONVERT;
            end
         end
         u2da_pkg::ST_CONVERT: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_BITS-1]};
            bin_in     = bin_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = DIG_CNT_W'(NUM_DIGITS);
               state_in   = u2da_pkg::ST_SKIP;
            end
         end
         u2da_pkg::ST_SKIP: begin
            if (top_digit == '0 && dig_cnt_ff > DIG_CNT_W'(1)) begin
               bcd_in     = bcd_ff << DB;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else begin
               state_in = u2da_pkg::ST_EMIT;
            end
         end
         u2da_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = u2da_pkg::ASCII_ZERO + u2da_pkg::CHAR_WIDTH'(top_digit);
               last_in      = (dig_cnt_ff == DIG_CNT_W'(1));
               bcd_in       = bcd_ff << DB;
               dig_cnt_in   = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == DIG_CNT_W'(1)) begin
                  state_in = u2da_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = u2da_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= u2da_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dig_cnt_ff   <= '0;
         bit_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dig_cnt_ff   <= dig_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last       = last_ff;

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (char_ff >= u2da_pkg::ASCII_ZERO &&
                        char_ff <= u2da_pkg::ASCII_ZERO + 6'd9))
      else $error("digit out of range");

   a_start_convert: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == u2da_pkg::ST_CONVERT))
      else $error("accepted word did not start conversion");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == u2da_pkg::ST_EMIT || state_ff == u2da_pkg::ST_SKIP)
         |-> (dig_cnt_ff != '0))
      else $error("digit count underflow");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == u2da_pkg::ST_EMIT && out_free && dig_cnt_ff == DIG_CNT_W'(1))
         |=> (state_ff == u2da_pkg::ST_IDLE && rsp_valid_ff && last_ff))
      else $error("final digit not flagged");

   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == u2da_pkg::ST_SKIP && state_in == u2da_pkg::ST_EMIT)
         |-> (top_digit != '0 || dig_cnt_ff == DIG_CNT_W'(1)))
      else $error("leading zero kept");

endmodule

@@ bench/u2da_bench_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u2da_bench_pkg
// digit scoreboard for the decimal ascii converter bench: turns every accepted
// binary word into the expected run of ascii digits and checks the returned
// digit words against it in order
// ----------------------------------------------------------------------------
package u2da_bench_pkg;

   localparam int IN_W    = u2da_pkg::IN_WIDTH;
   localparam int CHAR_W  = u2da_pkg::CHAR_WIDTH;
   localparam int DIGIT_W = u2da_pkg::DIGIT_BITS;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_word_type;

   class decimal_text_scoreboard_type;

      digit_word_type pending_digits[$];
      int unsigned    errors;
      int unsigned    values_noted;
      int unsigned    digits_checked;
      bit             lengths_seen[0:20];

      function void note_value(logic [IN_W-1:0] raw);
         longint unsigned    rest;
         logic [DIGIT_W-1:0] low_first[$];
         digit_word_type     w;
         rest = 64'(raw);
         if (u2da_pkg::VALUE_BITS_DEFAULT < 64) begin
            rest = rest & ((64'd1 << u2da_pkg::VALUE_BITS_DEFAULT) - 64'd1);
         end
         do begin
            low_first.push_back(DIGIT_W'(rest % 64'(u2da_pkg::DEC_BASE)));
            rest = rest / 64'(u2da_pkg::DEC_BASE);
         end while (rest != 0);
         lengths_seen[low_first.size()] = 1'b1;
         for (int k = low_first.size() - 1; k >= 0; k--) begin
            w.digit_char = u2da_pkg::ASCII_ZERO + CHAR_W'(low_first[k]);
            w.last       = (k == 0);
            pending_digits.push_back(w);
         end
         values_noted++;
      endfunction

      function void check_digit(logic [CHAR_W-1:0] digit_char, logic last);
         digit_word_type want;
         if (pending_digits.size() == 0) begin
            $error("unexpected digit word: digit_char %0d last %0b", digit_char, last);
            errors++;
            return;
         end
         want = pending_digits.pop_front();
         digits_checked++;
         if (digit_char !== want.digit_char) begin
            $error("digit_char: expected %0d, actual %0d", want.digit_char, digit_char);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            errors++;
         end
      endfunction

      function int unsigned lengths_covered();
         int unsigned count;
         count = 0;
         for (int n = 1; n <= 20; n++) begin
            if (lengths_seen[n]) count++;
         end
         return count;
      endfunction

   endclass

endpackage

@@ bench/unsigned_to_decimal_ascii_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii_top_tb
// self-checking bench for the decimal ascii converter: directed edge values
// (zero, single digits, powers of ten and their neighbors, all ones, alternating
// bit patterns) then random words of random bit length, sent in bursts with
// gaps against a receiver that stalls in several patterns and once holds off
// long enough to back the converter up into its input
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii_top_tb;

   localparam int IN_W   = u2da_pkg::IN_WIDTH;
   localparam int CHAR_W = u2da_pkg::CHAR_WIDTH;

   localparam int unsigned RANDOM_ITEMS    = 288;
   localparam int unsigned HOLD_OFF_AT     = 70;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES    = 60;
   localparam int unsigned CYCLE_LIMIT     = 200000;

   typedef enum int unsigned {
      RX_STEADY,
      RX_COIN,
      RX_MOSTLY,
      RX_PULSED
   } rx_mode_type;

   localparam logic [IN_W-1:0] EDGE_VALUES [25] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd999, 32'd1000,
      32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
      32'd10000000, 32'd100000000, 32'd999999999, 32'd1000000000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [IN_W-1:0]   req_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [CHAR_W-1:0] rsp_digit_char;
   logic              rsp_last;

   int unsigned cycle_count;
   int unsigned burst_left;
   bit          hold_off_request;
   bit          hold_off_done;

   u2da_bench_pkg::decimal_text_scoreboard_type scoreboard = new();

   unsigned_to_decimal_ascii_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      rsp_ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("unsigned_to_decimal_ascii_top_tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) scoreboard.note_value(req_value);
         if (rsp_valid && rsp_ready) scoreboard.check_digit(rsp_digit_char, rsp_last);
      end
   end

   task automatic send_value(input logic [IN_W-1:0] v);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value <= v;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   function automatic logic [IN_W-1:0] random_value();
      logic [IN_W-1:0] v;
      longint unsigned p;
      int unsigned     pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         v = $urandom >> (IN_W - $urandom_range(1, IN_W));
      end else if (pick <= 7) begin
         v = $urandom;
      end else if (pick == 8) begin
         p = 1;
         repeat ($urandom_range(0, 9)) p = p * 10;
         v = IN_W'(p + $urandom_range(0, 2) - 1);
      end else begin
         v = $urandom_range(0, 20);
      end
      return v;
   endfunction

   initial begin
      rx_mode_type mode;
      int unsigned span;
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            mode = rx_mode_type'($urandom_range(0, 3));
            span = $urandom_range(10, 150);
            repeat (span) begin
               case (mode)
                  RX_STEADY: rsp_ready <= 1'b1;
                  RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                  RX_MOSTLY: rsp_ready <= ($urandom_range(0, 4) != 0);
                  default:   rsp_ready <= (cycle_count[2:0] < 3'd3);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      burst_left       = 0;
      hold_off_request = 1'b0;
      hold_off_done    = 1'b0;
      do begin
         @(posedge clock);
      end while (reset);

      foreach (EDGE_VALUES[i]) send_value(EDGE_VALUES[i]);
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_OFF_AT) hold_off_request = 1'b1;
         send_value(random_value());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (scoreboard.pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d words into %0d checked digits; %0d distinct digit counts seen",
               scoreboard.values_noted, scoreboard.digits_checked,
               scoreboard.lengths_covered());
      $display("receiver held off %0d cycles once while words kept coming", HOLD_OFF_CYCLES);
      if (scoreboard.errors == 0) begin
         $display("unsigned_to_decimal_ascii_top_tb: clean");
      end else begin
         $display("unsigned_to_decimal_ascii_top_tb: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/u2da_pkg.sv
rtl/unsigned_to_decimal_ascii_top.sv
bench/u2da_bench_pkg.sv
bench/unsigned_to_decimal_ascii_top_tb.sv
